/* hw/rtl/mpct_pkg.sv */
`default_nettype none
package mpct_pkg;

  localparam int unsigned SCREEN_W = 11;
  localparam int unsigned CURSOR_W = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DELTA_W  = 9;
  // wide enough for pos + delta + cursor size, signed
  localparam int unsigned CALC_W   = 13;

  localparam int unsigned FIRST_MARK_BIT = 3;
  localparam int unsigned X_SIGN_BIT     = 4;
  localparam int unsigned Y_SIGN_BIT     = 5;
  localparam int unsigned LEFT_BIT       = 0;
  localparam int unsigned RIGHT_BIT      = 1;
  localparam int unsigned MIDDLE_BIT     = 2;

  localparam logic signed [CALC_W-1:0] EDGE_MARGIN = 13'sd2;

  localparam logic [SCREEN_W-1:0] SCREEN_W_RST = 11'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_H_RST = 11'd768;
  localparam logic [CURSOR_W-1:0] CURSOR_W_RST = 8'd16;
  localparam logic [CURSOR_W-1:0] CURSOR_H_RST = 8'd16;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_CURSOR_WIDTH  = 2'd2,
    REG_CURSOR_HEIGHT = 2'd3
  } reg_idx_t;

  // position within a packet
  typedef enum logic [1:0] {
    PKT_HEADER = 2'd0,
    PKT_XMOVE  = 2'd1,
    PKT_YMOVE  = 2'd2
  } pkt_state_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [CURSOR_W-1:0] cursor_width;
    logic [CURSOR_W-1:0] cursor_height;
  } geom_t;

endpackage
`default_nettype wire

/* hw/rtl/mpct_move.sv */
`default_nettype none
// Bounds check and new cursor position for one packet.
module mpct_move (
  input  wire mpct_pkg::geom_t                          geom,
  input  wire logic [mpct_pkg::SCREEN_W-1:0]           pos_x,
  input  wire logic [mpct_pkg::SCREEN_W-1:0]           pos_y,
  input  wire logic signed [mpct_pkg::DELTA_W-1:0]     delta_x,
  input  wire logic signed [mpct_pkg::DELTA_W-1:0]     delta_y,
  output logic [mpct_pkg::SCREEN_W-1:0]                new_x,
  output logic [mpct_pkg::SCREEN_W-1:0]                new_y
);

  logic signed [mpct_pkg::CALC_W-1:0] nx;
  logic signed [mpct_pkg::CALC_W-1:0] ny;
  logic signed [mpct_pkg::CALC_W-1:0] nx_far;
  logic signed [mpct_pkg::CALC_W-1:0] ny_far;
  logic signed [mpct_pkg::CALC_W-1:0] sw;
  logic signed [mpct_pkg::CALC_W-1:0] sh;
  logic                               fits;

  always_comb begin
    nx = $signed({2'b00, pos_x}) + mpct_pkg::CALC_W'(delta_x);
    ny = $signed({2'b00, pos_y}) - mpct_pkg::CALC_W'(delta_y);
    nx_far = nx + $signed({5'b0, geom.cursor_width});
    ny_far = ny + $signed({5'b0, geom.cursor_height});
    sw = $signed({2'b00, geom.screen_width});
    sh = $signed({2'b00, geom.screen_height});
    fits = (nx > mpct_pkg::EDGE_MARGIN) && (nx_far < sw) &&
           (ny > mpct_pkg::EDGE_MARGIN) && (ny_far < sh);
    // a failed check on either axis holds both
    new_x = fits ? nx[mpct_pkg::SCREEN_W-1:0] : pos_x;
    new_y = fits ? ny[mpct_pkg::SCREEN_W-1:0] : pos_y;
  end

endmodule
`default_nettype wire

/* hw/rtl/mouse_packet_cursor_tracker.sv */
`default_nettype none
// Throughput: one byte per cycle, except while a packet's third byte waits for room
//   in the result register; the input register and the result register decouple the
//   two sides, so a waiting result does not block framing bytes.
// Reset (rst_n low, synchronous): packet framing restarts at the header byte,
//   cursor goes to (0,0), screen 1024x768 and cursor 16x16 are restored.
module mouse_packet_cursor_tracker (
  input  wire                                       clk,
  input  wire                                       rst_n,
  // byte input
  input  wire                                       in_valid,
  output logic                                      in_stall,
  input  wire [mpct_pkg::BYTE_W-1:0]                in_mouse_byte,
  // result output
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output logic [mpct_pkg::SCREEN_W-1:0]             out_cursor_x,
  output logic [mpct_pkg::SCREEN_W-1:0]             out_cursor_y,
  output logic signed [mpct_pkg::DELTA_W-1:0]       out_delta_x,
  output logic signed [mpct_pkg::DELTA_W-1:0]       out_delta_y,
  output logic                                      out_left_button,
  output logic                                      out_middle_button,
  output logic                                      out_right_button,
  // register port
  input  wire                                       psel,
  input  wire                                       penable,
  input  wire                                       pwrite,
  input  wire [3:0]                                 paddr,
  input  wire [31:0]                                pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  // ---------------------------------------------------------------------
  // Geometry registers
  // ---------------------------------------------------------------------
  mpct_pkg::geom_t   geom_r;
  mpct_pkg::reg_idx_t reg_idx;
  logic              reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = mpct_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.screen_width  <= mpct_pkg::SCREEN_W_RST;
      geom_r.screen_height <= mpct_pkg::SCREEN_H_RST;
      geom_r.cursor_width  <= mpct_pkg::CURSOR_W_RST;
      geom_r.cursor_height <= mpct_pkg::CURSOR_H_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        mpct_pkg::REG_SCREEN_WIDTH:  geom_r.screen_width  <= pwdata[mpct_pkg::SCREEN_W-1:0];
        mpct_pkg::REG_SCREEN_HEIGHT: geom_r.screen_height <= pwdata[mpct_pkg::SCREEN_W-1:0];
        mpct_pkg::REG_CURSOR_WIDTH:  geom_r.cursor_width  <= pwdata[mpct_pkg::CURSOR_W-1:0];
        mpct_pkg::REG_CURSOR_HEIGHT: geom_r.cursor_height <= pwdata[mpct_pkg::CURSOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mpct_pkg::REG_SCREEN_WIDTH:  prdata = {21'b0, geom_r.screen_width};
      mpct_pkg::REG_SCREEN_HEIGHT: prdata = {21'b0, geom_r.screen_height};
      mpct_pkg::REG_CURSOR_WIDTH:  prdata = {24'b0, geom_r.cursor_width};
      mpct_pkg::REG_CURSOR_HEIGHT: prdata = {24'b0, geom_r.cursor_height};
      default:                     prdata = 32'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                        s1_valid_r;
  logic [mpct_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_done;   // held byte is consumed this cycle
  logic                        in_take;

  assign in_stall = s1_valid_r && !s1_done;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_mouse_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Packet framing and cursor state
  // ---------------------------------------------------------------------
  mpct_pkg::pkt_state_t          state_r, state_nxt;
  logic [mpct_pkg::BYTE_W-1:0]   header_r, header_nxt;
  logic [mpct_pkg::BYTE_W-1:0]   xmove_r, xmove_nxt;
  logic [mpct_pkg::SCREEN_W-1:0] pos_x_r, pos_x_nxt;
  logic [mpct_pkg::SCREEN_W-1:0] pos_y_r, pos_y_nxt;
  logic                          emit;
  logic                          out_free;

  logic signed [mpct_pkg::DELTA_W-1:0] dx;
  logic signed [mpct_pkg::DELTA_W-1:0] dy;
  logic [mpct_pkg::SCREEN_W-1:0]       mv_x;
  logic [mpct_pkg::SCREEN_W-1:0]       mv_y;

  logic                                out_valid_r;
  logic [mpct_pkg::SCREEN_W-1:0]       out_x_r;
  logic [mpct_pkg::SCREEN_W-1:0]       out_y_r;
  logic signed [mpct_pkg::DELTA_W-1:0] out_dx_r;
  logic signed [mpct_pkg::DELTA_W-1:0] out_dy_r;
  logic                                out_left_r;
  logic                                out_middle_r;
  logic                                out_right_r;

  assign out_free = !out_valid_r || !out_stall;

  // 9-bit deltas: sign bits ride in the header byte
  assign dx = $signed({header_r[mpct_pkg::X_SIGN_BIT], xmove_r});
  assign dy = $signed({header_r[mpct_pkg::Y_SIGN_BIT], s1_byte_r});

  mpct_move u_move (
    .geom    (geom_r),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .delta_x (dx),
    .delta_y (dy),
    .new_x   (mv_x),
    .new_y   (mv_y)
  );

  always_comb begin
    state_nxt  = state_r;
    header_nxt = header_r;
    xmove_nxt  = xmove_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    emit       = 1'b0;
    s1_done    = 1'b0;
    unique case (state_r)
      mpct_pkg::PKT_HEADER: begin
        s1_done = s1_valid_r;
        // out-of-sync bytes (no mark bit) are dropped here
        if (s1_valid_r && s1_byte_r[mpct_pkg::FIRST_MARK_BIT]) begin
          header_nxt = s1_byte_r;
          state_nxt  = mpct_pkg::PKT_XMOVE;
        end
      end
      mpct_pkg::PKT_XMOVE: begin
        s1_done = s1_valid_r;
        if (s1_valid_r) begin
          xmove_nxt = s1_byte_r;
          state_nxt = mpct_pkg::PKT_YMOVE;
        end
      end
      default: begin
        // third byte; needs room in the result register
        if (s1_valid_r && out_free) begin
          s1_done   = 1'b1;
          emit      = 1'b1;
          pos_x_nxt = mv_x;
          pos_y_nxt = mv_y;
          state_nxt = mpct_pkg::PKT_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mpct_pkg::PKT_HEADER;
      header_r <= '0;
      xmove_r  <= '0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      header_r <= header_nxt;
      xmove_r  <= xmove_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r      <= mv_x;
      out_y_r      <= mv_y;
      out_dx_r     <= dx;
      out_dy_r     <= dy;
      out_left_r   <= header_r[mpct_pkg::LEFT_BIT];
      out_middle_r <= header_r[mpct_pkg::MIDDLE_BIT];
      out_right_r  <= header_r[mpct_pkg::RIGHT_BIT];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_x      = out_x_r;
  assign out_cursor_y      = out_y_r;
  assign out_delta_x       = out_dx_r;
  assign out_delta_y       = out_dy_r;
  assign out_left_button   = out_left_r;
  assign out_middle_button = out_middle_r;
  assign out_right_button  = out_right_r;

endmodule
`default_nettype wire
